>>> hdl/dla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dla_pkg
// shared constants, codes and types of the dense layer with activation
// ----------------------------------------------------------------------------
package dla_pkg;

	localparam int OUT_MAX = 64;
	localparam int IN_MAX  = 256;
	localparam int OIDX_W  = $clog2(OUT_MAX);
	localparam int FIDX_W  = $clog2(IN_MAX);
	localparam int VAL_W   = 16;
	localparam int ACC_W   = 40;
	localparam int EXP_W   = 41;
	localparam int SUM_W   = 48;
	localparam int NUM_W   = 50;
	localparam int QUO_W   = 10;

	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_BIAS   = 2'd1;
	localparam logic [1:0] OP_FEAT   = 2'd2;

	localparam logic [2:0] ACT_LINEAR  = 3'd0;
	localparam logic [2:0] ACT_SIGMOID = 3'd1;
	localparam logic [2:0] ACT_RELU    = 3'd2;
	localparam logic [2:0] ACT_LEAKY   = 3'd3;
	localparam logic [2:0] ACT_SOFTMAX = 3'd4;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_SLOPE = 2'd1;
	localparam logic [1:0] REG_USED  = 2'd2;

	localparam logic [15:0] SLOPE_RST = 16'd19661;
	localparam logic [6:0]  USED_RST  = 7'd64;

	localparam logic [EXP_W-1:0] EXP_SAT = {1'b0, {(EXP_W-1){1'b1}}};

	// 2^(i/16) in q2.15
	localparam logic [16:0] POW2_TAB [17] = '{
		17'd32768, 17'd34219, 17'd35734, 17'd37316, 17'd38968, 17'd40693,
		17'd42495, 17'd44376, 17'd46341, 17'd48393, 17'd50535, 17'd52773,
		17'd55109, 17'd57549, 17'd60097, 17'd62758, 17'd65536
	};

	typedef struct packed {
		logic rd;
		logic mul;
		logic mac;
		logic open;
		logic shift;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/dla_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dla_cell
// one neuron: weight column memory, bias, multiplier and accumulator
// ----------------------------------------------------------------------------
module dla_cell import dla_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    wr_en,
	input  wire logic                    bias_en,
	input  wire cell_ctl_t               ctl,
	input  wire logic [FIDX_W-1:0]       addr,
	input  wire logic signed [VAL_W-1:0] wdata,
	input  wire logic signed [VAL_W-1:0] feat,
	input  wire logic signed [ACC_W-1:0] acc_in,
	output logic signed [ACC_W-1:0]      acc_out
);

	logic signed [VAL_W-1:0]   mem [IN_MAX];
	logic signed [VAL_W-1:0]   w_s1;
	logic signed [2*VAL_W-1:0] prod_s2;
	logic signed [VAL_W-1:0]   bias_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   base;
	logic signed [ACC_W:0]     sum;
	logic signed [ACC_W-1:0]   sat;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			w_s1 <= mem[addr];
		end
		if (ctl.mul) begin
			prod_s2 <= w_s1 * feat;
		end
		if (bias_en) begin
			bias_q <= wdata;
		end
	end

	// first feature of a vector starts from the bias
	assign base = ctl.open ? acc_q : {{(ACC_W-VAL_W-8){bias_q[VAL_W-1]}}, bias_q, 8'd0};
	assign sum  = {base[ACC_W-1], base} + (ACC_W+1)'(prod_s2);

	always_comb begin
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			sat = {sum[ACC_W], {(ACC_W-1){~sum[ACC_W]}}};
		end else begin
			sat = sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.mac) begin
			acc_q <= sat;
		end else if (ctl.shift) begin
			acc_q <= acc_in;
		end
	end

	assign acc_out = acc_q;

endmodule

`default_nettype wire

>>> hdl/dla_exp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dla_exp
// three-stage exponential: base-2 split, table interpolation, scaling
// ----------------------------------------------------------------------------
module dla_exp import dla_pkg::*; (
	input  wire logic               clk,
	input  wire logic signed [16:0] x,
	output logic [EXP_W-1:0]        y
);

	logic signed [25:0] y_s1;
	logic [16:0]        m_s2;
	logic signed [9:0]  e_s2;
	logic [EXP_W-1:0]   y_s3;

	logic [3:0]         ti;
	logic [11:0]        tr;
	logic [11:0]        diff;
	logic [23:0]        ip;
	logic [9:0]         s;
	logic [32:0]        rnd;

	assign ti   = y_s1[15:12];
	assign tr   = y_s1[11:0];
	assign diff = 12'(POW2_TAB[5'(ti) + 5'd1] - POW2_TAB[5'(ti)]);
	assign ip   = diff * tr;
	assign s    = 10'(-e_s2);
	assign rnd  = (33'(m_s2) + (33'd1 << (s[5:0] - 6'd1))) >> s[5:0];

	always_ff @(posedge clk) begin
		y_s1 <= x * 26'sd369;
		m_s2 <= POW2_TAB[5'(ti)] + 17'(ip[23:12]);
		e_s2 <= y_s1[25:16] + 10'sd1;
		if (e_s2 > 10'sd24) begin
			y_s3 <= EXP_SAT;
		end else if (e_s2 >= 10'sd0) begin
			y_s3 <= EXP_W'(m_s2) << e_s2[4:0];
		end else if (s > 10'd32) begin
			y_s3 <= '0;
		end else begin
			y_s3 <= EXP_W'(rnd);
		end
	end

	assign y = y_s3;

endmodule

`default_nettype wire

>>> hdl/dla_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dla_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dla_div import dla_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [SUM_W-1:0] den,
	output logic                  busy,
	output logic [QUO_W-1:0]      quo
);

	localparam int SH_W = SUM_W + QUO_W;

	logic [SH_W-1:0]  rem_q;
	logic [SH_W-1:0]  den_q;
	logic [QUO_W-1:0] quo_q;
	logic [3:0]       cnt_q;
	logic             busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'(QUO_W - 1);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 4'd1;
			busy_q <= (cnt_q != 4'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= SH_W'(num);
			den_q <= SH_W'(den) << (QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= den_q) begin
				rem_q <= rem_q - den_q;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			den_q <= den_q >> 1;
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

>>> hdl/dense_layer_with_activation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dense_layer_with_activation
// sparse-input dense layer over a ring of 64 neuron cells with activation
// ----------------------------------------------------------------------------
// usage
//  - input channel (in_valid/in_ready): op 0 writes a weight, op 1 a bias;
//    op 2 is a feature item, absorbed by every cell through weight read,
//    multiply and accumulate
//  - a feature with last_feature closes the vector: the accumulators rotate
//    around the cell ring and the head cell feeds one activation unit
//  - each result passes the exp pipe (3 stages), and for sigmoid and softmax
//    also the bit-serial divider, one quotient bit a cycle
//  - softmax first makes a full 64-step lap of the ring to sum exponentials
//  - in_ready is low while a vector is being emitted
//  - the result register holds its item while out_ready is low and the
//    sequencer waits; loads still complete into the idle block
//  - apb port: activation_mode at 0x0, leaky_slope at 0x4, outputs_used 0x8
//  - reset clears the control state and the registers to their defaults;
//    weights and biases hold garbage until loaded
// ----------------------------------------------------------------------------
module dense_layer_with_activation import dla_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [3:0]               paddr,
	input  wire logic [31:0]              pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               op,
	input  wire logic [OIDX_W-1:0]        out_index,
	input  wire logic [FIDX_W-1:0]        feature_index,
	input  wire logic signed [VAL_W-1:0]  value,
	input  wire logic                     last_feature,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [VAL_W-1:0]       result_value,
	output logic [OIDX_W-1:0]             result_index,
	output logic                          last_result
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_MAC, S_X, S_E1, S_E2, S_E3, S_D, S_DIV, S_OUT
	} state_t;

	state_t st_q;

	// configuration registers
	logic [2:0]  mode_q;
	logic [15:0] slope_q;
	logic [6:0]  used_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ACT_LINEAR;
			slope_q <= SLOPE_RST;
			used_q  <= USED_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MODE:  mode_q  <= pwdata[2:0];
				REG_SLOPE: slope_q <= pwdata[15:0];
				REG_USED:  used_q  <= pwdata[6:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MODE:  prdata = {29'd0, mode_q};
			REG_SLOPE: prdata = {16'd0, slope_q};
			REG_USED:  prdata = {25'd0, used_q};
			default:   prdata = '0;
		endcase
	end

	// neurons emitted: zero acts as one, beyond the ring acts as full
	logic [6:0] n_used;
	always_comb begin
		if (used_q == 7'd0) begin
			n_used = 7'd1;
		end else if (used_q > 7'(OUT_MAX)) begin
			n_used = 7'(OUT_MAX);
		end else begin
			n_used = used_q;
		end
	end

	// input side
	logic accept;
	assign in_ready = (st_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	logic signed [VAL_W-1:0] val_q;
	logic                    last_q;
	logic                    open_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= value;
			last_q <= last_feature;
		end
	end

	// cell ring, rotating toward cell 0 so neuron order comes out at the head
	cell_ctl_t                 ctl;
	logic                      shift;
	logic [OUT_MAX-1:0]        wr_en;
	logic [OUT_MAX-1:0]        bias_en;
	logic signed [ACC_W-1:0]   acc [OUT_MAX];

	assign ctl.rd    = accept && (op == OP_FEAT);
	assign ctl.mul   = (st_q == S_RD);
	assign ctl.mac   = (st_q == S_MAC);
	assign ctl.open  = open_q;
	assign ctl.shift = shift;

	for (genvar j = 0; j < OUT_MAX; j++) begin : g_cell
		assign wr_en[j]   = accept && (op == OP_WEIGHT) && (out_index == OIDX_W'(j));
		assign bias_en[j] = accept && (op == OP_BIAS) && (out_index == OIDX_W'(j));

		dla_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en[j]),
			.bias_en (bias_en[j]),
			.ctl     (ctl),
			.addr    (feature_index),
			.wdata   (value),
			.feat    (val_q),
			.acc_in  (acc[(j + 1) % OUT_MAX]),
			.acc_out (acc[j])
		);
	end

	// round the head accumulator to q8.8 with saturation
	logic signed [ACC_W:0]  acc_rnd;
	logic signed [32:0]     acc_sh;
	logic signed [15:0]     x_next;

	assign acc_rnd = {acc[0][ACC_W-1], acc[0]} + (ACC_W+1)'(128);
	assign acc_sh  = acc_rnd[ACC_W:8];

	always_comb begin
		if (acc_sh > 33'sd32767) begin
			x_next = 16'sh7fff;
		end else if (acc_sh < -33'sd32768) begin
			x_next = -16'sh8000;
		end else begin
			x_next = acc_sh[15:0];
		end
	end

	// activation datapath
	logic signed [15:0]      x_q;
	logic signed [16:0]      lk_q;
	logic signed [32:0]      lk_p;
	logic signed [16:0]      exp_x;
	logic [EXP_W-1:0]        exp_y;
	logic [SUM_W-1:0]        sum_q;
	logic                    sum_pass_q;
	logic [OIDX_W-1:0]       d_q;

	assign exp_x = (mode_q == ACT_SIGMOID) ? -17'(x_q) : 17'(x_q);
	assign lk_p  = x_q * $signed({1'b0, slope_q});

	dla_exp u_exp (
		.clk (clk),
		.x   (exp_x),
		.y   (exp_y)
	);

	logic              div_start;
	logic              div_busy;
	logic [QUO_W-1:0]  quo;
	logic [NUM_W-1:0]  div_num;
	logic [SUM_W-1:0]  div_den;
	logic [SUM_W-1:0]  sig_den;

	assign sig_den = SUM_W'(exp_y) + SUM_W'(65536);

	always_comb begin
		if (mode_q == ACT_SIGMOID) begin
			div_num = NUM_W'(25'd1 << 24) + NUM_W'(sig_den >> 1);
			div_den = sig_den;
		end else begin
			div_num = (NUM_W'(exp_y) << 8) + NUM_W'(sum_q >> 1);
			div_den = sum_q;
		end
	end

	assign div_start = (st_q == S_D) && !sum_pass_q &&
		((mode_q == ACT_SIGMOID) || ((mode_q == ACT_SOFTMAX) && (sum_q != '0)));

	dla_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (quo)
	);

	// activated value of the current neuron
	logic signed [VAL_W-1:0] r_val;
	always_comb begin
		unique case (mode_q)
			ACT_SIGMOID: r_val = VAL_W'(quo);
			ACT_RELU:    r_val = x_q[15] ? '0 : x_q;
			ACT_LEAKY:   r_val = x_q[15] ? lk_q[15:0] : x_q;
			ACT_SOFTMAX: r_val = (sum_q == '0) ? '0 : VAL_W'(quo);
			default:     r_val = x_q;
		endcase
	end

	// emit loads the result register whenever it is empty or being drained
	logic out_free;
	logic emit;
	assign out_free = !out_valid || out_ready;
	assign emit     = (st_q == S_OUT) && out_free;
	assign shift    = ((st_q == S_D) && sum_pass_q) || emit;

	// sequencer with the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			open_q       <= 1'b0;
			sum_pass_q   <= 1'b0;
			sum_q        <= '0;
			d_q          <= '0;
			x_q          <= '0;
			lk_q         <= '0;
			out_valid    <= 1'b0;
			result_value <= '0;
			result_index <= '0;
			last_result  <= 1'b0;
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept && (op == OP_FEAT)) begin
						st_q <= S_RD;
					end
				end
				S_RD: st_q <= S_MAC;
				S_MAC: begin
					open_q <= !last_q;
					d_q    <= '0;
					if (last_q) begin
						sum_pass_q <= (mode_q == ACT_SOFTMAX);
						sum_q      <= '0;
						st_q       <= S_X;
					end else begin
						st_q <= S_IDLE;
					end
				end
				S_X: begin
					x_q  <= x_next;
					st_q <= S_E1;
				end
				S_E1: begin
					lk_q <= 17'((lk_p + 33'sd32768) >>> 16);
					st_q <= S_E2;
				end
				S_E2: st_q <= S_E3;
				S_E3: st_q <= S_D;
				S_D: begin
					if (sum_pass_q) begin
						if (7'(d_q) < n_used) begin
							sum_q <= sum_q + SUM_W'(exp_y);
						end
						d_q <= d_q + OIDX_W'(1);
						if (d_q == OIDX_W'(OUT_MAX - 1)) begin
							sum_pass_q <= 1'b0;
						end
						st_q <= S_X;
					end else if (div_start) begin
						st_q <= S_DIV;
					end else begin
						st_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (!div_busy) begin
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						result_value <= r_val;
						result_index <= d_q;
						last_result  <= (7'(d_q) == n_used - 7'd1);
						if (7'(d_q) == n_used - 7'd1) begin
							st_q <= S_IDLE;
						end else begin
							d_q  <= d_q + OIDX_W'(1);
							st_q <= S_X;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> tb/tb_dense_layer_with_activation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dense_layer_with_activation
// self-checking bench: loads weights and biases, streams sparse input vectors
// through every activation over several register settings and idle patterns,
// and checks each emitted neuron output against a cycle-free behavioral copy
// ----------------------------------------------------------------------------
module tb_dense_layer_with_activation import dla_pkg::*; ();

	localparam longint ACC_HI  = 64'sd549755813887;
	localparam longint ACC_LO  = -ACC_HI - 1;
	localparam longint unsigned EXP_TOP = 64'd1099511627775;
	localparam int     LIMIT   = 4000000;
	localparam int     SETTLE  = 200;

	// op code with no meaning, and an activation code beyond the list
	localparam logic [1:0] OP_IGNORED  = 2'd3;
	localparam logic [2:0] ACT_UNKNOWN = 3'd7;

	typedef struct {
		logic [1:0]               op;
		logic [OIDX_W-1:0]        oi;
		logic [FIDX_W-1:0]        fi;
		logic signed [VAL_W-1:0]  val;
		logic                     last;
	} layer_item_t;

	typedef struct {
		logic signed [VAL_W-1:0]  val;
		logic [OIDX_W-1:0]        idx;
		logic                     last;
	} neuron_out_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic [1:0] op;
	logic [OIDX_W-1:0] out_index;
	logic [FIDX_W-1:0] feature_index;
	logic signed [VAL_W-1:0] value;
	logic last_feature;
	logic out_valid, out_ready;
	logic signed [VAL_W-1:0] result_value;
	logic [OIDX_W-1:0] result_index;
	logic last_result;

	dense_layer_with_activation dut (.*);

	// shadow of the layer: memories, accumulators and registers
	logic signed [VAL_W-1:0] w_mem [OUT_MAX][IN_MAX];
	logic signed [VAL_W-1:0] b_mem [OUT_MAX];
	longint acc [OUT_MAX];
	bit vec_open;
	logic [2:0] act_mode;
	logic [15:0] slope;
	logic [6:0] n_used;

	layer_item_t pending_items [$];
	neuron_out_t expected_outs [$];
	int n_pushed, n_taken, n_outs, n_errors, n_vectors;
	int send_idle, recv_stall;
	bit took;
	longint cycles;

	// feature columns whose whole weight column has been written
	int loaded_cols [2] = '{0, 255};

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// exponential in q24.16 via 2^(x*log2 e), table plus linear interpolation
	function automatic longint unsigned exp_q16(longint x);
		longint y, k, e, s;
		int unsigned f, i, r, m, t0, t1;
		y = x * 369;
		k = y >>> 16;
		f = int'(y - k * 65536);
		i = (f >> 12) & 15;
		r = f & 4095;
		t0 = 32'(POW2_TAB[i]);
		t1 = 32'(POW2_TAB[i + 1]);
		m = t0 + (((t1 - t0) * r) >> 12);
		e = k + 1;
		if (e > 24) return EXP_TOP;
		if (e >= 0) return longint'(m) << e;
		s = -e;
		if (s > 32) return 0;
		return (longint'(m) + (64'd1 << (s - 1))) >> s;
	endfunction

	function automatic longint round_q88(longint a);
		longint x;
		x = (a + 128) >>> 8;
		if (x > 32767) x = 32767;
		if (x < -32768) x = -32768;
		return x;
	endfunction

	// advance the shadow layer by one item and queue the outputs it causes
	function automatic void absorb_item(layer_item_t it);
		longint x, r, t;
		longint unsigned sum, den;
		int n;
		neuron_out_t o;
		if (it.op == OP_WEIGHT) begin
			w_mem[it.oi][it.fi] = it.val;
			return;
		end
		if (it.op == OP_BIAS) begin
			b_mem[it.oi] = it.val;
			return;
		end
		if (it.op != OP_FEAT) return;
		if (!vec_open) begin
			for (int d = 0; d < OUT_MAX; d++) acc[d] = longint'(b_mem[d]) * 256;
			vec_open = 1;
		end
		for (int d = 0; d < OUT_MAX; d++) begin
			t = acc[d] + longint'(w_mem[d][it.fi]) * longint'(it.val);
			acc[d] = (t > ACC_HI) ? ACC_HI : (t < ACC_LO) ? ACC_LO : t;
		end
		if (!it.last) return;
		vec_open = 0;
		n = n_used;
		if (n < 1) n = 1;
		if (n > OUT_MAX) n = OUT_MAX;
		sum = 0;
		if (act_mode == ACT_SOFTMAX)
			for (int d = 0; d < n; d++) sum += exp_q16(round_q88(acc[d]));
		for (int d = 0; d < n; d++) begin
			x = round_q88(acc[d]);
			r = x;
			case (act_mode)
				ACT_SIGMOID: begin
					den = 64'd65536 + exp_q16(-x);
					r = longint'(((64'd1 << 24) + den / 2) / den);
				end
				ACT_RELU: if (x < 0) r = 0;
				ACT_LEAKY: if (x < 0) r = (x * longint'(slope) + 32768) >>> 16;
				ACT_SOFTMAX: r = (sum == 0) ? 0 : longint'((exp_q16(x) * 256 + sum / 2) / sum);
				default: ;
			endcase
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			o.val = r[15:0];
			o.idx = d[OIDX_W-1:0];
			o.last = (d == n - 1);
			expected_outs = {expected_outs, o};
		end
		n_vectors++;
	endfunction

	task automatic send(input logic [1:0] o, input int oi, input int fi,
			input logic [15:0] v, input bit l);
		layer_item_t it;
		it.op = o;
		it.oi = oi[OIDX_W-1:0];
		it.fi = fi[FIDX_W-1:0];
		it.val = v;
		it.last = l;
		absorb_item(it);
		pending_items = {pending_items, it};
		n_pushed++;
	endtask

	// wait until all items are in and all outputs are out, then let it settle
	task automatic drain();
		wait (n_taken == n_pushed && expected_outs.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// apb write: setup cycle, then access cycle
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MODE: act_mode = data[2:0];
			REG_SLOPE: slope = data[15:0];
			REG_USED: n_used = data[6:0];
			default: ;
		endcase
	endtask

	task automatic random_vector();
		int nf;
		nf = $urandom_range(1, 5);
		for (int j = 0; j < nf; j++) begin
			// occasional load inside an open vector
			if ($urandom_range(9) == 0)
				send(OP_BIAS, $urandom_range(63), $urandom_range(255), 16'($urandom),
					1'($urandom_range(1)));
			send(OP_FEAT, $urandom_range(63), loaded_cols[$urandom_range(1)],
				16'($urandom), j == nf - 1);
		end
	endtask

	task automatic random_noise();
		case ($urandom_range(3))
			0: send(OP_WEIGHT, $urandom_range(63), loaded_cols[$urandom_range(1)],
					16'($urandom), 1'($urandom_range(1)));
			1: send(OP_BIAS, $urandom_range(63), $urandom_range(255), 16'($urandom),
					1'($urandom_range(1)));
			2: send(OP_IGNORED, $urandom_range(63), $urandom_range(255), 16'($urandom),
					1'($urandom_range(1)));
			default: random_vector();
		endcase
	endtask

	// stimulus: setup loads, directed cases, then random phases
	initial begin
		logic [2:0] modes [6] = '{ACT_LINEAR, ACT_SIGMOID, ACT_RELU, ACT_LEAKY, ACT_SOFTMAX,
			ACT_UNKNOWN};
		int used_set [6] = '{64, 1, 0, 127, 7, 3};
		int slope_set [6] = '{0, 65535, 19661, 65535, 0, 1};
		int base;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		send_idle = 0; recv_stall = 0;
		n_pushed = 0; n_errors = 0; n_vectors = 0;
		vec_open = 0; act_mode = ACT_LINEAR; slope = SLOPE_RST; n_used = USED_RST;
		for (int d = 0; d < OUT_MAX; d++) acc[d] = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// fill biases and the weight columns in use, extremes on the corners
		for (int d = 0; d < OUT_MAX; d++)
			send(OP_BIAS, d, 0, (d == 0) ? 16'h7fff : (d == 63) ? 16'h8000 : 16'($urandom),
				1'b0);
		foreach (loaded_cols[c])
			for (int d = 0; d < OUT_MAX; d++)
				send(OP_WEIGHT, d, loaded_cols[c],
					(d == 0) ? 16'h7fff : (d == 63) ? 16'h8000 : 16'($urandom), 1'b0);

		// directed: extreme values, repeated index, loads inside a vector,
		// last flag on loads, ignored op code
		send(OP_FEAT, 0, 0, 16'h7fff, 1'b0);
		send(OP_FEAT, 0, 0, 16'h7fff, 1'b0);
		send(OP_FEAT, 63, 255, 16'h8000, 1'b1);
		send(OP_FEAT, 0, 255, 16'h0000, 1'b1);
		send(OP_BIAS, 5, 255, 16'h0100, 1'b1);
		send(OP_FEAT, 0, 255, 16'hffff, 1'b0);
		send(OP_BIAS, 6, 0, 16'h8000, 1'b0);
		send(OP_WEIGHT, 7, 0, 16'h7fff, 1'b1);
		send(OP_IGNORED, 63, 255, 16'hffff, 1'b1);
		send(OP_FEAT, 0, 0, 16'h0100, 1'b1);
		send(OP_FEAT, 0, 255, 16'h5555, 1'b1);
		send(OP_FEAT, 0, 0, 16'haaaa, 1'b1);

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			reg_write(REG_MODE, 32'(modes[ph]));
			reg_write(REG_SLOPE, 32'(slope_set[ph]));
			reg_write(REG_USED, 32'(used_set[ph]));
			send_idle = (ph % 4 == 1) ? 60 : (ph % 4 == 3) ? 6 : 0;
			recv_stall = (ph % 4 == 2) ? 60 : (ph % 4 == 3) ? 6 : 0;
			// directed extremes under each activation
			send(OP_FEAT, 0, 0, 16'h7fff, 1'b1);
			send(OP_FEAT, 0, 255, 16'h7fff, 1'b1);
			base = n_pushed;
			while (n_pushed - base < 6) begin
				if ($urandom_range(3) == 0) random_noise();
				else random_vector();
				// hold off until everything outstanding has come back
				if ($urandom_range(7) == 0)
					wait (n_taken == n_pushed && expected_outs.size() == 0);
			end
		end
		drain();
		$display("covered %0d items and %0d vectors, %0d outputs checked", n_pushed,
			n_vectors, n_outs);
		$display("activations linear, sigmoid, relu, leaky, softmax, unknown code; idle mixes");
		if (n_errors == 0 && expected_outs.size() == 0)
			$display("dense_layer_with_activation verification clean");
		else
			$display("dense_layer_with_activation verification failed");
		$finish;
	end

	// item acceptance, seen at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			took <= 1'b0;
			n_taken <= 0;
		end else begin
			took <= in_valid && in_ready;
			if (in_valid && in_ready) n_taken <= n_taken + 1;
		end
	end

	// driver: present the next pending item at the falling edge
	always @(negedge clk) begin
		layer_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_WEIGHT;
			out_index <= '0;
			feature_index <= '0;
			value <= '0;
			last_feature <= 1'b0;
		end else if (!in_valid || took) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
				it = pending_items.pop_front();
				op <= it.op;
				out_index <= it.oi;
				feature_index <= it.fi;
				value <= it.val;
				last_feature <= it.last;
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver back-pressure
	always @(negedge clk)
		if (!arst_n) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(99) >= recv_stall);

	// monitor: compare each output against the oldest expectation
	always @(posedge clk) begin
		neuron_out_t e;
		if (arst_n && out_valid && out_ready) begin
			n_outs++;
			if (expected_outs.size() == 0) begin
				$display("%0t: unexpected output value %0d index %0d", $time,
					result_value, result_index);
				n_errors++;
			end else begin
				e = expected_outs.pop_front();
				if (result_value !== e.val || result_index !== e.idx || last_result !== e.last) begin
					$display("%0t: output mismatch exp val %0d idx %0d last %0b, got val %0d idx %0d last %0b",
						$time, e.val, e.idx, e.last, result_value, result_index, last_result);
					n_errors++;
				end
			end
		end
	end

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("dense_layer_with_activation verification failed");
			$finish;
		end
	end

endmodule
